// ===== sv/imhq_pkg.sv =====
package imhq_pkg;

    localparam int MODE_W   = 2;
    localparam int NODE_W   = 10;
    localparam int KEY_W    = 32;
    localparam int COUNT_W  = 11;
    localparam int STATUS_W = 3;

    localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
    localparam logic [MODE_W-1:0] MODE_UPDATE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK            = 3'd0;
    localparam logic [STATUS_W-1:0] ST_REMOVE_EMPTY  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_INSERT_FULL   = 3'd2;
    localparam logic [STATUS_W-1:0] ST_UPDATE_ABSENT = 3'd3;
    localparam logic [STATUS_W-1:0] ST_INSERT_PRESENT = 3'd4;

    typedef struct packed {
        logic [MODE_W-1:0] mode;
        logic [NODE_W-1:0] node_index;
        logic [KEY_W-1:0]  node_key;
    } in_word_t;

    typedef struct packed {
        logic [NODE_W-1:0]   removed_node;
        logic [KEY_W-1:0]    removed_key;
        logic [NODE_W-1:0]   top_node;
        logic [KEY_W-1:0]    top_key;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } out_word_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LOOKUP,
        ST_CHECK,
        ST_RM_RD_LAST,
        ST_RM_LAST_KEY,
        ST_RM_PLACE,
        ST_UP_RD_PARENT,
        ST_UP_PARENT_KEY,
        ST_UP_CMP,
        ST_DN_RD_LEFT,
        ST_DN_LEFT_KEY,
        ST_DN_RD_RIGHT,
        ST_DN_RIGHT_KEY,
        ST_DN_CMP,
        ST_TOP_RD,
        ST_TOP_KEY,
        ST_DONE,
        ST_OUT
    } seq_state_t;

endpackage

// ===== sv/imhq_if.sv =====
interface imhq_in_if;
    import imhq_pkg::*;
    logic     valid;
    logic     ready;
    in_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/imhq_out_if.sv =====
interface imhq_out_if;
    import imhq_pkg::*;
    logic      valid;
    logic      ready;
    out_word_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/indexed_min_heap_queue.sv =====
// channel  dir  word
// in_ch    in   mode, node_index, node_key
// out_ch   out  removed_node, removed_key, top_node, top_key, entry_count, status
// one word at a time; a heap level sifting up steps through parent read, parent key
// and compare, and sifting down through left read, left key, right read, right key
// and compare, each step waiting on one registered read of the slot, node or key memory
// reset runs a clear of every entry of the node-to-slot map before in_ch is ready
// a result held in out_ch blocks the next word until taken
module indexed_min_heap_queue #(
    parameter int NODES = 1024
) (
    input logic     clk,
    input logic     rst_n,
    imhq_in_if.sink   in_ch,
    imhq_out_if.source out_ch
);
    import imhq_pkg::*;

    localparam int AW = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int SW = $clog2(NODES + 1);

    logic [NODE_W-1:0] heap_mem [1:NODES];
    logic [SW-1:0]     slot_mem [0:NODES-1];
    logic [KEY_W-1:0]  key_mem  [0:NODES-1];

    seq_state_t state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [AW-1:0]       node_reg, node_next;
    logic [KEY_W-1:0]    key_reg, key_next;
    logic [SW-1:0]       count_reg, count_next;
    logic [SW-1:0]       loc_reg, loc_next;
    logic [SW-1:0]       child_reg, child_next;
    logic [NODE_W-1:0]   other_reg, other_next;
    logic [KEY_W-1:0]    okey_reg, okey_next;
    logic [NODE_W-1:0]   lnode_reg, lnode_next;
    logic [KEY_W-1:0]    lkey_reg, lkey_next;
    logic                upd_reg, upd_next;
    logic                clr_reg, clr_next;
    logic [SW-1:0]       clr_cnt_reg, clr_cnt_next;
    out_word_t           res_reg, res_next;
    logic                in_range;

    // memory ports
    logic              heap_we;
    logic [SW-1:0]     heap_waddr, heap_raddr;
    logic [NODE_W-1:0] heap_wdata, heap_rdata;
    logic              slot_we;
    logic [AW-1:0]     slot_waddr, slot_raddr;
    logic [SW-1:0]     slot_wdata, slot_rdata;
    logic              key_we;
    logic [AW-1:0]     key_waddr, key_raddr;
    logic [KEY_W-1:0]  key_wdata, key_rdata;

    always_ff @(posedge clk)
    begin
        if (heap_we)
        begin
            heap_mem[heap_waddr] <= heap_wdata;
        end
        heap_rdata <= heap_mem[heap_raddr];
        if (slot_we)
        begin
            slot_mem[slot_waddr] <= slot_wdata;
        end
        slot_rdata <= slot_mem[slot_raddr];
        if (key_we)
        begin
            key_mem[key_waddr] <= key_wdata;
        end
        key_rdata <= key_mem[key_raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            clr_reg     <= 1'b1;
            clr_cnt_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            clr_reg     <= clr_next;
            clr_cnt_reg <= clr_cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg  <= mode_next;
        node_reg  <= node_next;
        key_reg   <= key_next;
        loc_reg   <= loc_next;
        child_reg <= child_next;
        other_reg <= other_next;
        okey_reg  <= okey_next;
        lnode_reg <= lnode_next;
        lkey_reg  <= lkey_next;
        upd_reg   <= upd_next;
        res_reg   <= res_next;
    end

    assign in_ch.ready  = (state_reg == ST_IDLE) && !clr_reg;
    assign out_ch.valid = (state_reg == ST_OUT);
    assign out_ch.data  = res_reg;
    assign in_range     = ({{(SW){1'b0}}, in_ch.data.node_index} < (SW + NODE_W)'(NODES));

    always_comb
    begin
        state_next   = state_reg;
        mode_next    = mode_reg;
        node_next    = node_reg;
        key_next     = key_reg;
        count_next   = count_reg;
        loc_next     = loc_reg;
        child_next   = child_reg;
        other_next   = other_reg;
        okey_next    = okey_reg;
        lnode_next   = lnode_reg;
        lkey_next    = lkey_reg;
        upd_next     = upd_reg;
        res_next     = res_reg;
        clr_next     = clr_reg;
        clr_cnt_next = clr_cnt_reg;
        heap_we    = 1'b0;
        heap_waddr = loc_reg;
        heap_wdata = NODE_W'(node_reg);
        heap_raddr = loc_reg;
        slot_we    = 1'b0;
        slot_waddr = node_reg;
        slot_wdata = loc_reg;
        slot_raddr = node_reg;
        key_we     = 1'b0;
        key_waddr  = node_reg;
        key_wdata  = key_reg;
        key_raddr  = AW'(heap_rdata);

        if (clr_reg)
        begin
            slot_we    = 1'b1;
            slot_waddr = clr_cnt_reg[AW-1:0];
            slot_wdata = '0;
            clr_cnt_next = clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == SW'(NODES - 1))
            begin
                clr_next = 1'b0;
            end
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_ch.valid && in_ch.ready)
                begin
                    mode_next = in_ch.data.mode;
                    node_next = AW'(in_ch.data.node_index);
                    key_next  = in_ch.data.node_key;
                    res_next  = '0;
                    upd_next  = 1'b0;
                    if (in_ch.data.mode == MODE_INSERT && !in_range)
                    begin
                        res_next.status = ST_INSERT_FULL;
                        state_next = ST_TOP_RD;
                    end
                    else if (in_ch.data.mode == MODE_UPDATE && !in_range)
                    begin
                        res_next.status = ST_UPDATE_ABSENT;
                        state_next = ST_TOP_RD;
                    end
                    else if (in_ch.data.mode == MODE_INSERT ||
                             in_ch.data.mode == MODE_UPDATE)
                    begin
                        state_next = ST_LOOKUP;
                    end
                    else if (in_ch.data.mode == MODE_REMOVE)
                    begin
                        if (count_reg == '0)
                        begin
                            res_next.status = ST_REMOVE_EMPTY;
                            state_next = ST_TOP_RD;
                        end
                        else
                        begin
                            loc_next   = SW'(1);
                            state_next = ST_RM_RD_LAST;
                        end
                    end
                    else
                    begin
                        state_next = ST_TOP_RD;
                    end
                end
            end
            ST_LOOKUP:
            begin
                slot_raddr = node_reg;
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (mode_reg == MODE_INSERT)
                begin
                    if (slot_rdata != '0)
                    begin
                        res_next.status = ST_INSERT_PRESENT;
                        state_next = ST_TOP_RD;
                    end
                    else if (count_reg >= SW'(NODES))
                    begin
                        res_next.status = ST_INSERT_FULL;
                        state_next = ST_TOP_RD;
                    end
                    else
                    begin
                        count_next = count_reg + 1'b1;
                        loc_next   = count_reg + 1'b1;
                        key_we     = 1'b1;
                        state_next = ST_UP_RD_PARENT;
                    end
                end
                else
                begin
                    if (slot_rdata == '0)
                    begin
                        res_next.status = ST_UPDATE_ABSENT;
                        state_next = ST_TOP_RD;
                    end
                    else
                    begin
                        loc_next   = slot_rdata;
                        key_we     = 1'b1;
                        upd_next   = 1'b1;
                        state_next = ST_UP_RD_PARENT;
                    end
                end
            end
            // remove: root read was issued at loc 1 during this state
            ST_RM_RD_LAST:
            begin
                heap_raddr = SW'(1);
                state_next = ST_RM_LAST_KEY;
            end
            ST_RM_LAST_KEY:
            begin
                key_raddr  = AW'(heap_rdata);
                res_next.removed_node = heap_rdata;
                heap_raddr = count_reg;
                slot_we    = 1'b1;
                slot_waddr = AW'(heap_rdata);
                slot_wdata = '0;
                state_next = ST_RM_PLACE;
            end
            ST_RM_PLACE:
            begin
                res_next.removed_key = key_rdata;
                key_raddr  = AW'(heap_rdata);
                node_next  = AW'(heap_rdata);
                count_next = count_reg - 1'b1;
                loc_next   = SW'(1);
                if (count_reg == SW'(1))
                begin
                    state_next = ST_TOP_RD;
                end
                else
                begin
                    state_next = ST_DN_RD_LEFT;
                    upd_next   = 1'b1;
                    mode_next  = MODE_REMOVE;
                end
            end
            ST_UP_RD_PARENT:
            begin
                if (mode_reg == MODE_REMOVE && upd_reg && loc_reg == SW'(1) &&
                    child_reg == '0)
                begin
                    state_next = ST_DN_RD_LEFT;
                end
                if (loc_reg <= SW'(1))
                begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = upd_reg ? ST_DN_RD_LEFT : ST_TOP_RD;
                end
                else
                begin
                    heap_raddr = loc_reg >> 1;
                    state_next = ST_UP_PARENT_KEY;
                end
            end
            ST_UP_PARENT_KEY:
            begin
                other_next = heap_rdata;
                key_raddr  = AW'(heap_rdata);
                state_next = ST_UP_CMP;
            end
            ST_UP_CMP:
            begin
                if (key_reg < key_rdata)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = other_reg;
                    slot_we    = 1'b1;
                    slot_waddr = AW'(other_reg);
                    loc_next   = loc_reg >> 1;
                    state_next = ST_UP_RD_PARENT;
                end
                else
                begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = upd_reg ? ST_DN_RD_LEFT : ST_TOP_RD;
                end
            end
            ST_DN_RD_LEFT:
            begin
                // in remove the key of the moved node arrives here once
                if (mode_reg == MODE_REMOVE && loc_reg == SW'(1) && upd_reg)
                begin
                    key_next = key_rdata;
                    upd_next = 1'b0;
                end
                if ({loc_reg, 1'b0} > {1'b0, count_reg})
                begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = ST_TOP_RD;
                end
                else
                begin
                    heap_raddr = SW'({loc_reg, 1'b0});
                    child_next = SW'({loc_reg, 1'b0});
                    state_next = ST_DN_LEFT_KEY;
                end
            end
            ST_DN_LEFT_KEY:
            begin
                lnode_next = heap_rdata;
                key_raddr  = AW'(heap_rdata);
                heap_raddr = child_reg + 1'b1;
                state_next = ST_DN_RD_RIGHT;
            end
            ST_DN_RD_RIGHT:
            begin
                lkey_next  = key_rdata;
                other_next = heap_rdata;
                key_raddr  = AW'(heap_rdata);
                state_next = ST_DN_RIGHT_KEY;
            end
            ST_DN_RIGHT_KEY:
            begin
                okey_next = lkey_reg;
                if ({1'b0, child_reg} + 1'b1 <= {1'b0, count_reg} && key_rdata < lkey_reg)
                begin
                    okey_next  = key_rdata;
                    child_next = child_reg + 1'b1;
                end
                else
                begin
                    other_next = lnode_reg;
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP:
            begin
                if (key_reg > okey_reg)
                begin
                    heap_we    = 1'b1;
                    heap_wdata = other_reg;
                    slot_we    = 1'b1;
                    slot_waddr = AW'(other_reg);
                    loc_next   = child_reg;
                    state_next = ST_DN_RD_LEFT;
                end
                else
                begin
                    heap_we    = 1'b1;
                    slot_we    = 1'b1;
                    state_next = ST_TOP_RD;
                end
            end
            ST_TOP_RD:
            begin
                heap_raddr = SW'(1);
                state_next = ST_TOP_KEY;
            end
            ST_TOP_KEY:
            begin
                key_raddr  = AW'(heap_rdata);
                other_next = heap_rdata;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                res_next.entry_count = COUNT_W'(count_reg);
                if (count_reg != '0)
                begin
                    res_next.top_node = other_reg;
                    res_next.top_key  = key_rdata;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_ch.ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== bench/tb_indexed_min_heap_queue.sv =====
module tb_indexed_min_heap_queue;
    import imhq_pkg::*;

    localparam int NODES = 1024;
    localparam int STALL_LIMIT = 20000;
    localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

    logic clk;
    logic rst_n;

    imhq_in_if  in_ch ();
    imhq_out_if out_ch ();

    indexed_min_heap_queue #(.NODES(NODES)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .in_ch  (in_ch.sink),
        .out_ch (out_ch.source)
    );

    // heap model
    logic [NODE_W-1:0]  slot_node [0:NODES];
    logic [COUNT_W-1:0] node_slot [0:NODES-1];
    logic [KEY_W-1:0]   node_keys [0:NODES-1];
    int unsigned        held;

    in_word_t  pending_words [$];
    out_word_t expected_words [$];
    int        errors;
    int        idle_cycles;
    int        burst_left;
    int        gap_left;
    int        stall_phase;
    bit        hold_off;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic void place(int unsigned slot, logic [NODE_W-1:0] node);
        slot_node[slot] = node;
        node_slot[node] = COUNT_W'(slot);
    endfunction

    function automatic int unsigned bubble_up(int unsigned loc);
        logic [NODE_W-1:0] node;
        logic [KEY_W-1:0]  k;
        node = slot_node[loc];
        k = node_keys[node];
        while (loc > 1 && k < node_keys[slot_node[loc / 2]])
        begin
            place(loc, slot_node[loc / 2]);
            loc = loc / 2;
        end
        place(loc, node);
        return loc;
    endfunction

    function automatic void bubble_down(int unsigned loc);
        logic [NODE_W-1:0] node;
        logic [KEY_W-1:0]  k;
        int unsigned       l;
        int unsigned       c;
        node = slot_node[loc];
        k = node_keys[node];
        forever
        begin
            l = 2 * loc;
            if (l > held)
                break;
            c = l;
            if (l + 1 <= held && node_keys[slot_node[l + 1]] < node_keys[slot_node[l]])
                c = l + 1;
            if (k > node_keys[slot_node[c]])
            begin
                place(loc, slot_node[c]);
                loc = c;
            end
            else
                break;
        end
        place(loc, node);
    endfunction

    function automatic out_word_t heap_step(in_word_t w);
        out_word_t r;
        logic [NODE_W-1:0] top;
        r = '0;
        r.status = ST_OK;
        if (w.mode == MODE_INSERT)
        begin
            if (node_slot[w.node_index] != 0)
                r.status = ST_INSERT_PRESENT;
            else if (held >= NODES)
                r.status = ST_INSERT_FULL;
            else
            begin
                held++;
                node_keys[w.node_index] = w.node_key;
                place(held, w.node_index);
                void'(bubble_up(held));
            end
        end
        else if (w.mode == MODE_UPDATE)
        begin
            if (node_slot[w.node_index] == 0)
                r.status = ST_UPDATE_ABSENT;
            else
            begin
                node_keys[w.node_index] = w.node_key;
                bubble_down(bubble_up(node_slot[w.node_index]));
            end
        end
        else if (w.mode == MODE_REMOVE)
        begin
            if (held == 0)
                r.status = ST_REMOVE_EMPTY;
            else
            begin
                top = slot_node[1];
                r.removed_node = top;
                r.removed_key = node_keys[top];
                node_slot[top] = 0;
                if (held > 1)
                begin
                    place(1, slot_node[held]);
                    held--;
                    bubble_down(1);
                end
                else
                    held = 0;
            end
        end
        if (held > 0)
        begin
            r.top_node = slot_node[1];
            r.top_key = node_keys[slot_node[1]];
        end
        r.entry_count = COUNT_W'(held);
        return r;
    endfunction

    function automatic in_word_t make_word(logic [MODE_W-1:0] m, int unsigned n,
                                           logic [KEY_W-1:0] k);
        in_word_t w;
        w.mode = m;
        w.node_index = NODE_W'(n);
        w.node_key = k;
        return w;
    endfunction

    function automatic logic [KEY_W-1:0] rand_key();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return KEY_W'($urandom_range(0, 7));
            default: return $urandom;
        endcase
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.data <= '0;
            burst_left <= 0;
            gap_left <= 0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (in_ch.valid && in_ch.ready)
                expected_words.push_back(heap_step(in_ch.data));
            if (gap_left > 0 || pending_words.size() == 0 || hold_off)
            begin
                in_ch.valid <= 1'b0;
                if (gap_left > 0)
                    gap_left <= gap_left - 1;
            end
            else
            begin
                in_ch.valid <= 1'b1;
                in_ch.data <= pending_words.pop_front();
                if (burst_left == 0)
                begin
                    burst_left <= $urandom_range(1, 30);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
                end
                else
                    burst_left <= burst_left - 1;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ch.ready <= 1'b0;
            stall_phase <= 0;
            idle_cycles <= 0;
        end
        else
        begin
            stall_phase <= stall_phase + 1;
            out_ch.ready <= (stall_phase % 64 < 20) ? 1'b1 : ($urandom_range(0, 3) != 0);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (out_ch.valid && out_ch.ready)
            begin
                if (expected_words.size() == 0)
                begin
                    $display("%0t unexpected word: expected none, actual %h",
                             $time, out_ch.data);
                    errors++;
                end
                else
                begin
                    out_word_t e;
                    e = expected_words.pop_front();
                    if (out_ch.data.removed_node !== e.removed_node)
                        $display("%0t removed_node: expected %0d, actual %0d",
                                 $time, e.removed_node, out_ch.data.removed_node);
                    if (out_ch.data.removed_key !== e.removed_key)
                        $display("%0t removed_key: expected %h, actual %h",
                                 $time, e.removed_key, out_ch.data.removed_key);
                    if (out_ch.data.top_node !== e.top_node)
                        $display("%0t top_node: expected %0d, actual %0d",
                                 $time, e.top_node, out_ch.data.top_node);
                    if (out_ch.data.top_key !== e.top_key)
                        $display("%0t top_key: expected %h, actual %h",
                                 $time, e.top_key, out_ch.data.top_key);
                    if (out_ch.data.entry_count !== e.entry_count)
                        $display("%0t entry_count: expected %0d, actual %0d",
                                 $time, e.entry_count, out_ch.data.entry_count);
                    if (out_ch.data.status !== e.status)
                        $display("%0t status: expected %0d, actual %0d",
                                 $time, e.status, out_ch.data.status);
                    if (out_ch.data !== e)
                        errors++;
                end
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (idle_cycles >= STALL_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    initial
    begin
        int unsigned n;
        int unsigned r;
        errors = 0;
        held = 0;
        hold_off = 1'b0;
        for (int i = 0; i < NODES; i++)
            node_slot[i] = '0;
        rst_n = 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // directed
        pending_words.push_back(make_word(MODE_REMOVE, 0, '0));
        pending_words.push_back(make_word(MODE_UPDATE, 5, 32'd9));
        pending_words.push_back(make_word(MODE_INSERT, 1023, '1));
        pending_words.push_back(make_word(MODE_INSERT, 0, 32'd0));
        pending_words.push_back(make_word(MODE_INSERT, 0, 32'd7));
        pending_words.push_back(make_word(MODE_INSERT, 7, 32'd100));
        pending_words.push_back(make_word(MODE_INSERT, 8, 32'd100));
        pending_words.push_back(make_word(MODE_INSERT, 9, 32'd50));
        pending_words.push_back(make_word(MODE_UPDATE, 0, '1));
        pending_words.push_back(make_word(MODE_UPDATE, 1023, 32'd0));
        pending_words.push_back(make_word(MODE_UNUSED, 511, 32'h5555_aaaa));
        pending_words.push_back(make_word(MODE_UPDATE, 9, 32'd100));
        for (int i = 0; i < 7; i++)
            pending_words.push_back(make_word(MODE_REMOVE, 682, 32'haaaa_5555));

        // random traffic, including words of the unused mode
        for (int i = 0; i < 900; i++)
        begin
            r = $urandom_range(0, 99);
            if (i == 450)
            begin
                // fill the heap completely
                for (int k = 0; k < NODES; k++)
                    pending_words.push_back(make_word(MODE_INSERT, k, rand_key()));
                pending_words.push_back(make_word(MODE_INSERT, $urandom_range(0, 1023), '0));
            end
            else if (r < 45)
            begin
                n = $urandom_range(0, 1023);
                pending_words.push_back(make_word(MODE_INSERT, n, rand_key()));
            end
            else if (r < 70)
                pending_words.push_back(make_word(MODE_UPDATE, $urandom_range(0, 63),
                                                  rand_key()));
            else if (r < 97)
                pending_words.push_back(make_word(MODE_REMOVE, $urandom_range(0, 1023),
                                                  $urandom));
            else
                pending_words.push_back(make_word(MODE_UNUSED, $urandom_range(0, 1023),
                                                  $urandom));
            if (i == 300)
            begin
                wait (pending_words.size() == 0);
                hold_off = 1'b1;
                @(posedge clk);
                wait (!in_ch.valid);
                wait (expected_words.size() == 0);
                repeat (80) @(posedge clk);
                hold_off = 1'b0;
            end
        end

        wait (pending_words.size() == 0);
        @(posedge clk);
        wait (!in_ch.valid);
        wait (expected_words.size() == 0);
        repeat (100) @(posedge clk);
        if (errors == 0 && expected_words.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
